// File: rtl/ttsp_pkg.sv
// Shared types, constants and score helper for the transposition table store/probe unit.
`default_nettype none

package ttsp_pkg;

  // Table geometry: power-of-two slot count, indexed by the low key bits
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ENTRIES = 1 << IDX_W;

  // Field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned FLAG_W  = 2;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned PLY_W   = 6;
  localparam int unsigned THR_W   = 15;

  localparam int unsigned IN_DATA_W  = 144;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [THR_W-1:0] MATE_THR_RESET = 15'd30000;

  // Request kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  // Bound flags
  localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_EXACT = 2'd2;

  // Input beat layout, first field in the lowest bits
  typedef struct packed {
    logic [1:0]                pad;
    logic signed [SCORE_W-1:0] beta;
    logic signed [SCORE_W-1:0] alpha;
    logic [PLY_W-1:0]          ply;
    logic [DEPTH_W-1:0]        depth;
    logic [FLAG_W-1:0]         bound_flag;
    logic signed [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]         move;
    logic [KEY_W-1:0]          key;
  } in_beat_t;

  // Output beat layout, first field in the lowest bits
  typedef struct packed {
    logic [4:0]                pad;
    logic signed [SCORE_W-1:0] score_out;
    logic                      cutoff;
    logic [MOVE_W-1:0]         move_out;
    logic                      key_match;
    logic                      stored;
  } out_beat_t;

  // One table slot
  typedef struct packed {
    logic                      valid;
    logic [KEY_W-1:0]          key;
    logic [MOVE_W-1:0]         move;
    logic signed [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0]        depth;
    logic [FLAG_W-1:0]         flag;
  } slot_t;

  // Shift a mate score by ply (away from zero when away is set, else toward), saturating
  function automatic logic signed [SCORE_W-1:0] ply_correct(
    input logic signed [SCORE_W-1:0] sc,
    input logic [PLY_W-1:0]          ply,
    input logic [THR_W-1:0]          thr,
    input logic                      away
  );
    logic signed [17:0] s;
    logic signed [17:0] t;
    logic signed [17:0] p;
    logic signed [17:0] r;
    s = {{2{sc[SCORE_W-1]}}, sc};
    t = {3'b000, thr};
    p = {12'd0, ply};
    r = s;
    if (s > t) begin
      r = away ? (s + p) : (s - p);
    end else if (s < -t) begin
      r = away ? (s - p) : (s + p);
    end
    if (r > 18'sd32767) begin
      ply_correct = 16'sh7FFF;
    end else if (r < -18'sd32768) begin
      ply_correct = 16'sh8000;
    end else begin
      ply_correct = r[SCORE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/transposition_table_store_probe_unit.sv
// Top level: direct-mapped, depth-preferred transposition table with store and probe requests.
// Flow: at accept the request is captured and its slot is read into rd_q_r; in ST_EXEC the slot is
// evaluated and written back, and the result is registered into out_beat_r with out_tvalid.
// A new request is not accepted until the previous one's read-modify-write of its slot is done;
// a stalled output holds ST_EXEC until it drains.
// Reset: rst_n low clears control state and the threshold register (30000); afterwards a
// clearing pass zeroes every slot's valid bit while in_tready stays low.
`default_nettype none

module transposition_table_store_probe_unit
  import ttsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata: key, move, score, bound_flag, depth, ply, alpha, beta, zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: kind
  input  wire logic                  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata: stored, key_match, move_out, cutoff, score_out, zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [THR_W-1:0]      cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [THR_W-1:0]   mate_thr_r;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r;
  out_beat_t          res_beat;
  in_beat_t           req_r;
  logic               req_kind_r;
  slot_t              tbl_mem [ENTRIES];
  slot_t              rd_q_r;
  slot_t              wr_slot;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  logic               in_acc;
  logic               exec_go;
  logic               do_store;
  logic               hit;
  logic signed [SCORE_W-1:0] probe_sc;
  in_beat_t           in_beat;

  assign in_beat   = in_beat_t'(in_tdata);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mate_thr_r <= MATE_THR_RESET;
    end else if (cfg_wr_en) begin
      mate_thr_r <= cfg_wr_data;
    end
  end

  // Capture the request at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r      <= in_beat;
      req_kind_r <= in_tuser;
    end
  end

  // Evaluate store or probe against the slot read back
  always_comb begin
    res_beat = '0;
    do_store = 1'b0;
    probe_sc = '0;
    hit      = rd_q_r.valid && (rd_q_r.key == req_r.key);
    if (req_kind_r == KIND_STORE) begin
      do_store        = !rd_q_r.valid || (rd_q_r.depth <= req_r.depth);
      res_beat.stored = do_store;
    end else if (hit) begin
      res_beat.key_match = 1'b1;
      res_beat.move_out  = rd_q_r.move;
      if (rd_q_r.depth >= req_r.depth) begin
        probe_sc           = ply_correct(rd_q_r.score, req_r.ply, mate_thr_r, 1'b0);
        res_beat.score_out = probe_sc;
        unique case (rd_q_r.flag)
          FLAG_UPPER: begin
            if (probe_sc <= req_r.alpha) begin
              res_beat.score_out = req_r.alpha;
              res_beat.cutoff    = 1'b1;
            end
          end
          FLAG_LOWER: begin
            if (probe_sc >= req_r.beta) begin
              res_beat.score_out = req_r.beta;
              res_beat.cutoff    = 1'b1;
            end
          end
          FLAG_EXACT: begin
            res_beat.cutoff = 1'b1;
          end
          default: begin
            res_beat.cutoff = 1'b0;
          end
        endcase
      end
    end
  end

  // Select the write port: clearing sweep or store write-back
  always_comb begin
    mem_we  = 1'b0;
    wr_idx  = req_r.key[IDX_W-1:0];
    wr_slot = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      wr_idx = clr_cnt_r;
    end else if (exec_go && do_store) begin
      mem_we        = 1'b1;
      wr_slot.valid = 1'b1;
      wr_slot.key   = req_r.key;
      wr_slot.move  = req_r.move;
      wr_slot.score = ply_correct(req_r.score, req_r.ply, mate_thr_r, 1'b1);
      wr_slot.depth = req_r.depth;
      wr_slot.flag  = req_r.bound_flag;
    end
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[wr_idx] <= wr_slot;
    end
    if (in_acc) begin
      rd_q_r <= tbl_mem[in_beat.key[IDX_W-1:0]];
    end
  end

  // Sequence control
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_beat_r;

endmodule

`default_nettype wire

// File: rtl/ttsp_checker.sv
// Port-level checker for the transposition table unit, bound to the top level.
`default_nettype none

module ttsp_checker
  import ttsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  out_beat_t beat;
  assign beat = out_beat_t'(out_tdata);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // One request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted in back-to-back cycles");

  // A result is either a store outcome or a probe outcome
  a_store_xor_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(beat.stored && beat.key_match))
    else $error("stored and key_match both set");

  // A cutoff needs a key match
  a_cut_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && beat.cutoff |-> beat.key_match)
    else $error("cutoff without key match");

  // Without a match, move and score are zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !beat.key_match |-> (beat.move_out == '0) && (beat.score_out == '0))
    else $error("nonzero move or score without key match");

endmodule

bind transposition_table_store_probe_unit ttsp_checker u_ttsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/transposition_table_store_probe_unit_tb.sv
// Self-checking testbench for the transposition table store/probe unit.
`timescale 1ns / 100ps

module transposition_table_store_probe_unit_tb;
  import ttsp_pkg::*;

  localparam logic [FLAG_W-1:0] FLAG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_BEATS = 206;

  typedef struct packed {
    logic     kind;
    in_beat_t beat;
  } tt_request_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [THR_W-1:0]      cfg_wr_data = '0;

  // Shadow table and threshold
  slot_t            shadow_table [ENTRIES];
  logic [THR_W-1:0] shadow_thr = MATE_THR_RESET;

  tt_request_t pending_reqs [$];
  out_beat_t   expected_results [$];
  int          reqs_queued = 0;
  int          reqs_accepted = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  transposition_table_store_probe_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic int clamp_score(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Apply one request to the shadow table and return the beat it should produce
  function automatic out_beat_t table_access(logic kind, in_beat_t req);
    out_beat_t res;
    int idx;
    int sc;
    int thr;
    int ply;
    int alpha;
    int beta;
    res   = '0;
    idx   = int'(req.key[IDX_W-1:0]);
    thr   = int'(shadow_thr);
    ply   = int'(req.ply);
    sc    = req.score;
    alpha = req.alpha;
    beta  = req.beta;
    if (kind == KIND_STORE) begin
      if (!shadow_table[idx].valid || shadow_table[idx].depth <= req.depth) begin
        // push mate scores away from zero
        if (sc > thr) sc = clamp_score(sc + ply);
        else if (sc < -thr) sc = clamp_score(sc - ply);
        shadow_table[idx].valid = 1'b1;
        shadow_table[idx].key   = req.key;
        shadow_table[idx].move  = req.move;
        shadow_table[idx].score = sc[SCORE_W-1:0];
        shadow_table[idx].depth = req.depth;
        shadow_table[idx].flag  = req.bound_flag;
        res.stored = 1'b1;
      end
    end else if (shadow_table[idx].valid && shadow_table[idx].key == req.key) begin
      res.key_match = 1'b1;
      res.move_out  = shadow_table[idx].move;
      if (shadow_table[idx].depth >= req.depth) begin
        // pull mate scores back toward zero
        sc = shadow_table[idx].score;
        if (sc > thr) sc = clamp_score(sc - ply);
        else if (sc < -thr) sc = clamp_score(sc + ply);
        case (shadow_table[idx].flag)
          FLAG_UPPER: begin
            if (sc <= alpha) begin
              sc = alpha;
              res.cutoff = 1'b1;
            end
          end
          FLAG_LOWER: begin
            if (sc >= beta) begin
              sc = beta;
              res.cutoff = 1'b1;
            end
          end
          FLAG_EXACT: res.cutoff = 1'b1;
          default: ;
        endcase
        res.score_out = sc[SCORE_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Mix of raw patterns, in-range values, values near the mate threshold and extremes
  function automatic logic [15:0] pick_score();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 64000) - 32000;
      2: begin
        v = int'(shadow_thr) + $urandom_range(0, 200) - 100;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32767;
          1: v = -32768;
          2: v = 32000;
          default: v = -32000;
        endcase
      end
      default: v = $urandom_range(0, 400) - 200;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [5:0] pick_depth();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
  endfunction

  task automatic queue_req(input logic kind, input logic [63:0] key, input logic [15:0] move,
                           input logic [15:0] score, input logic [1:0] flag,
                           input logic [5:0] depth, input logic [5:0] ply,
                           input logic [15:0] alpha, input logic [15:0] beta);
    tt_request_t r;
    r.kind            = kind;
    r.beat.pad        = '0;
    r.beat.key        = key;
    r.beat.move       = move;
    r.beat.score      = score;
    r.beat.bound_flag = flag;
    r.beat.depth      = depth;
    r.beat.ply        = ply;
    r.beat.alpha      = alpha;
    r.beat.beta       = beta;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Hold until every queued beat is accepted and every result has come back
  task automatic wait_drained();
    while (reqs_accepted != reqs_queued || expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_thr  = value;
  endtask

  // Random requests over a small key pool plus occasional fresh keys, some pool keys sharing a slot index
  task automatic queue_random_phase(input int count);
    logic [63:0] pool [16];
    logic [63:0] k;
    logic [1:0]  flag;
    int i;
    for (i = 0; i < 16; i++) begin
      k = rand_key();
      if (i % 4 == 3) k[IDX_W-1:0] = pool[i-1][IDX_W-1:0];
      pool[i] = k;
    end
    for (i = 0; i < count; i++) begin
      k = pool[$urandom_range(0, 15)];
      if ($urandom_range(0, 7) == 0) k = rand_key();
      flag = ($urandom_range(0, 9) == 0) ? FLAG_SPARE : 2'($urandom_range(0, 2));
      queue_req(($urandom_range(0, 9) < 4) ? KIND_STORE : KIND_PROBE, k, 16'($urandom),
                pick_score(), flag, pick_depth(), 6'($urandom_range(0, 63)),
                pick_score(), pick_score());
    end
  endtask

  // Driver: present queued beats with random gaps, predict each accepted one
  int  tx_idle = 0;
  bit  tx_steady = 1'b0;
  tt_request_t tx_req;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_idle = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(table_access(in_tuser, in_beat_t'(in_tdata)));
        reqs_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_idle == 0 && pending_reqs.size() != 0) begin
          tx_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= tx_req.kind;
          in_tdata  <= tx_req.beat;
          if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
          tx_idle = tx_steady ? 0 : $urandom_range(0, 9);
        end else begin
          in_tvalid <= 1'b0;
          if (tx_idle != 0) tx_idle--;
        end
      end
    end
  end

  // Monitor: stall the result side at random and compare each beat in order
  int  rx_hold = 0;
  bit  rx_steady = 1'b0;
  out_beat_t rx_want;
  out_beat_t rx_got;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_got = out_beat_t'(out_tdata);
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          rx_want = expected_results.pop_front();
          check_field("stored", 16'(rx_want.stored), 16'(rx_got.stored));
          check_field("key_match", 16'(rx_want.key_match), 16'(rx_got.key_match));
          check_field("move_out", rx_want.move_out, rx_got.move_out);
          check_field("cutoff", 16'(rx_want.cutoff), 16'(rx_got.cutoff));
          check_field("score_out", rx_want.score_out, rx_got.score_out);
        end
        if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
        rx_hold = rx_steady ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: abort after a long stretch with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("transposition_table_store_probe_unit_tb: FAIL");
      $finish;
    end
  end

  logic [63:0] k0, k1, k2, k3, k4;
  logic [THR_W-1:0] phase_thr [5];
  int p;
  initial begin
    for (p = 0; p < ENTRIES; p++) shadow_table[p] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_threshold(MATE_THR_RESET);

    k0 = rand_key();
    k1 = {~k0[63:IDX_W], k0[IDX_W-1:0]};
    k2 = rand_key();
    if (k2[IDX_W-1:0] == k0[IDX_W-1:0]) k2[IDX_W-1:0] = ~k0[IDX_W-1:0];
    k3 = '0;
    k4 = '1;

    // Directed: empty slot, saturation, replacement by depth, every bound flag
    queue_req(KIND_PROBE, k0, 16'h0000, 0, FLAG_UPPER, 0, 0, 0, 0);
    queue_req(KIND_STORE, k0, 16'hFFFF, 32767, FLAG_EXACT, 63, 63, 0, 0);
    queue_req(KIND_PROBE, k0, 16'h0000, 0, FLAG_UPPER, 63, 0, -32768, 32767);
    queue_req(KIND_PROBE, k0, 16'h0000, 0, FLAG_UPPER, 0, 63, 0, 0);
    queue_req(KIND_STORE, k0, 16'h1234, 100, FLAG_UPPER, 62, 0, 0, 0);
    queue_req(KIND_STORE, k2, 16'h0001, -32768, FLAG_LOWER, 0, 63, 0, 0);
    queue_req(KIND_PROBE, k2, 16'h0000, 0, FLAG_UPPER, 0, 0, 0, -32768);
    queue_req(KIND_PROBE, k2, 16'h0000, 0, FLAG_UPPER, 0, 10, 0, 0);
    queue_req(KIND_PROBE, k1, 16'h0000, 0, FLAG_UPPER, 0, 0, 0, 0);
    queue_req(KIND_STORE, k3, 16'h8000, 100, FLAG_UPPER, 10, 5, 0, 0);
    queue_req(KIND_PROBE, k3, 16'h0000, 0, FLAG_UPPER, 11, 0, 100, 0);
    queue_req(KIND_PROBE, k3, 16'h0000, 0, FLAG_UPPER, 10, 0, 100, 0);
    queue_req(KIND_PROBE, k3, 16'h0000, 0, FLAG_UPPER, 5, 0, -32000, 0);
    queue_req(KIND_STORE, k4, 16'h7FFF, -32000, FLAG_SPARE, 20, 5, 0, 0);
    queue_req(KIND_PROBE, k4, 16'h0000, 0, FLAG_UPPER, 20, 63, 32767, -32768);
    queue_req(KIND_STORE, k0, 16'h5555, 31000, FLAG_LOWER, 63, 0, 0, 0);
    queue_req(KIND_PROBE, k0, 16'h0000, 0, FLAG_UPPER, 63, 0, 0, 32000);
    queue_req(KIND_PROBE, k0, 16'h0000, 0, FLAG_UPPER, 0, 1, 0, -32768);
    queue_req(KIND_PROBE, k0, 16'hFFFF, -1, FLAG_SPARE, 0, 63, 16'h8000, 16'h7FFF);

    // Random phases, one threshold each, the unit drained between them
    phase_thr[0] = 15'd32767;
    phase_thr[1] = 15'd0;
    phase_thr[2] = 15'd32000;
    phase_thr[3] = 15'($urandom_range(1, 32766));
    phase_thr[4] = MATE_THR_RESET;
    for (p = 0; p < 5; p++) begin
      wait_drained();
      write_threshold(phase_thr[p]);
      queue_random_phase(PHASE_BEATS);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("transposition_table_store_probe_unit_tb: PASS");
    end else begin
      $display("transposition_table_store_probe_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
